// ===== design/jrv_pkg.sv =====
// Shared types, constants and the CRC32C byte step for the journal record validator.
// No dependencies.
`default_nettype none
package jrv_pkg;
   localparam int OBJECT_BYTES = 160;
   localparam int DIGEST_BYTES = 32;
   localparam logic [31:0] CRC_POLY = 32'h82f63b78;
   localparam logic [7:0] CRC_END = 8'd144;
   localparam logic [7:0] PAD_START = 8'd148;
   localparam logic [7:0] LAST_POS = 8'(OBJECT_BYTES - 1);
   localparam logic [7:0] SEL_PAD_START = 8'd104;
   localparam logic [7:0] REC_PAD_START = 8'd136;
   localparam logic [7:0] REC_DIGEST_START = 8'd64;
   localparam logic [7:0] SEL_DIGEST_START = 8'd40;
   localparam logic [7:0] DIGEST_SPAN = 8'(2 * DIGEST_BYTES);

   // config register indexes
   localparam logic [2:0] REG_FORMAT_SELECT = 3'd0;
   localparam logic [2:0] REG_MAX_TRIAL     = 3'd1;
   localparam logic [2:0] REG_CONFIRMED     = 3'd2;
   localparam logic [2:0] REG_TRIAL         = 3'd3;
   localparam logic [2:0] REG_SLOT_COUNT    = 3'd4;

   // header tag, bytes 0..14; byte 13 differs for the selector layout
   localparam logic [7:0] MAGIC [15] = '{
      8'h52, 8'h49, 8'h42, 8'h4F, 8'h4E, 8'h2D, 8'h50, 8'h53,
      8'h54, 8'h41, 8'h54, 8'h45, 8'h2D, 8'h52, 8'h31
   };
   localparam logic [7:0] SEL_TAG_BYTE = 8'h53;

   typedef struct packed {
      logic             bad;
      logic [3:0]       kind;
      logic [3:0]       slot;
      logic [63:0]      generation;
      logic [63:0]      floor_seq;
      logic [63:0]      trial_seq;
      logic [7:0]       attempts_left;
      logic [63:0]      boot_seq;
      logic [7:0][63:0] digest;
   } obj_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction
endpackage
`default_nettype wire

// ===== design/journal_record_validator_unit.sv =====
// Journal record validator top level: parser, summary queue, result emitter.
// Takes one byte per cycle while full is low; an object's summary is registered in the queue
// at its last byte, then gives 1 word (corrupt) or 9 words (valid), one per cycle while popped.
// full rises only when two finished objects wait in the summary queue.
// Synchronous active-high reset: position zero, CRC all ones, queue empty, registers
// at their defaults.
`default_nettype none
module journal_record_validator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [0:0]  req_start_flag,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [0:0]       rsp_status,
   output logic [3:0]       rsp_kind,
   output logic [3:0]       rsp_slot,
   output logic [63:0]      rsp_generation,
   output logic [63:0]      rsp_floor_seq,
   output logic [63:0]      rsp_trial_seq,
   output logic [7:0]       rsp_attempts_left,
   output logic [63:0]      rsp_boot_seq,
   output logic [63:0]      rsp_digest_word,
   output logic [3:0]       rsp_word_index,
   output logic [0:0]       rsp_last_flag,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_write_data
);
   import jrv_pkg::*;

   logic    obj_push, q_full, q_empty, q_pop;
   obj_type obj_entry, q_head;

   assign req_full = q_full;

   jrv_front u_front (
      .clock(clock), .reset(reset),
      .byte_valid(req_push && !q_full),
      .data_byte(req_data_byte), .start_flag(req_start_flag[0]),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .obj_push(obj_push), .obj_entry(obj_entry)
   );

   jrv_queue u_queue (
      .clock(clock), .reset(reset),
      .push(obj_push), .push_entry(obj_entry),
      .pop(q_pop), .full(q_full), .empty(q_empty), .head(q_head)
   );

   jrv_back u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty),
      .rsp_status(rsp_status[0]), .rsp_kind(rsp_kind), .rsp_slot(rsp_slot),
      .rsp_generation(rsp_generation), .rsp_floor_seq(rsp_floor_seq),
      .rsp_trial_seq(rsp_trial_seq),
      .rsp_attempts_left(rsp_attempts_left),
      .rsp_boot_seq(rsp_boot_seq),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_flag(rsp_last_flag)
   );

   a_corrupt_single: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status[0]) |-> (rsp_last_flag[0] && rsp_word_index == 4'd0))
      else $error("corrupt status word is not a single final word");

   a_digest_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word_index == 4'd8) |-> rsp_last_flag[0])
      else $error("eighth digest word not marked last");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queue not empty after reset");
endmodule
`default_nettype wire

// ===== design/jrv_front.sv =====
// Byte parser: CRC, field checks, field capture and final verdict per object.
// Uses jrv_pkg; pushes one finished object summary per object into the queue.
`default_nettype none
module jrv_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            byte_valid,
   input  wire logic [7:0]      data_byte,
   input  wire logic            start_flag,
   input  wire logic            csr_write_enable,
   input  wire logic [2:0]      csr_index,
   input  wire logic [7:0]      csr_write_data,
   output logic                 obj_push,
   output jrv_pkg::obj_type     obj_entry
);
   import jrv_pkg::*;

   logic        format_ff;
   logic [7:0]  max_trial_ff;
   logic [3:0]  confirmed_ff;
   logic [3:0]  trial_ff;
   logic [4:0]  slot_count_ff;

   logic [7:0]  pos_ff, pos_in;
   logic [31:0] crc_ff, crc_in;
   logic        err_ff, err_in;
   logic [63:0] shift_ff, shift_in;
   logic [1:0]  dz_ff, dz_in;
   logic [31:0] kind_ff, att_ff;
   logic [63:0] gen_ff, floor_ff, pend_ff, aseq_ff;
   logic [7:0][63:0] digest_ff;

   logic [7:0]  p;
   logic [31:0] crc_base;
   logic        err_base;
   logic [31:0] hi;
   logic [7:0]  d0, off;
   logic        in_digest;
   logic        last_byte;
   logic        bad;
   logic [4:0]  lim;
   logic        is_conf, is_trial, bind_ok;
   logic [63:0] floor_plus;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff     <= 1'b0;
         max_trial_ff  <= 8'd3;
         confirmed_ff  <= 4'd1;
         trial_ff      <= 4'd2;
         slot_count_ff <= 5'd2;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_FORMAT_SELECT: format_ff     <= csr_write_data[0];
            REG_MAX_TRIAL:     max_trial_ff  <= csr_write_data;
            REG_CONFIRMED:     confirmed_ff  <= csr_write_data[3:0];
            REG_TRIAL:         trial_ff      <= csr_write_data[3:0];
            REG_SLOT_COUNT:    slot_count_ff <= csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      p         = (start_flag || pos_ff > LAST_POS) ? 8'd0 : pos_ff;
      crc_base  = (p == 8'd0) ? 32'hFFFF_FFFF : crc_ff;
      err_base  = (p == 8'd0) ? 1'b0 : err_ff;
      dz_in     = (p == 8'd0) ? 2'b11 : dz_ff;
      crc_in    = (p < CRC_END) ? crc_byte(crc_base, data_byte) : crc_base;
      shift_in  = {data_byte, shift_ff[63:8]};
      hi        = shift_in[63:32];
      err_in    = err_base;
      d0        = format_ff ? SEL_DIGEST_START : REC_DIGEST_START;
      off       = p - d0;
      in_digest = (p >= d0) && (p < d0 + DIGEST_SPAN);
      last_byte = (p == LAST_POS);
      pos_in    = last_byte ? 8'd0 : p + 8'd1;

      if (p < 8'd15) begin
         if (data_byte != ((p == 8'd13 && format_ff) ? SEL_TAG_BYTE : MAGIC[p[3:0]]))
            err_in = 1'b1;
      end else if (p == 8'd16) begin
         if (data_byte != 8'd1) err_in = 1'b1;
      end else if (p < 8'd20) begin
         if (data_byte != 8'd0) err_in = 1'b1;
      end else if (p == 8'd23) begin
         if (hi != 32'(OBJECT_BYTES)) err_in = 1'b1;
      end else if (p == 8'd27) begin
         if (!format_ff && hi != 32'd1) err_in = 1'b1;
      end else if (p == 8'd31) begin
         if (format_ff && hi != 32'd0) err_in = 1'b1;
      end else if (p == 8'd147) begin
         if (hi != ~crc_base) err_in = 1'b1;
      end else if (p >= PAD_START) begin
         if (data_byte != 8'd0) err_in = 1'b1;
      end

      if (in_digest) begin
         if (data_byte != 8'd0) begin
            if (off[5]) dz_in[1] = 1'b0;
            else        dz_in[0] = 1'b0;
         end
      end else if (format_ff) begin
         if (p >= SEL_PAD_START && p < CRC_END && data_byte != 8'd0) err_in = 1'b1;
      end else begin
         if (p == 8'd63 && hi != 32'd0) err_in = 1'b1;
         if (p >= REC_PAD_START && p < CRC_END && data_byte != 8'd0) err_in = 1'b1;
      end

      // verdict at the final byte, with the registers as they stand now
      lim        = (slot_count_ff > 5'd16) ? 5'd16 : slot_count_ff;
      is_conf    = (kind_ff == {28'd0, confirmed_ff});
      is_trial   = (kind_ff == {28'd0, trial_ff});
      bind_ok    = (dz_in[1] == (aseq_ff == 64'd0));
      floor_plus = floor_ff + 64'd1;
      bad        = err_in || gen_ff == 64'd0 || dz_in[0];
      if (format_ff) begin
         if (kind_ff >= {27'd0, lim} || dz_in[1]) bad = 1'b1;
      end else begin
         if (!is_conf && !is_trial) bad = 1'b1;
         if (is_conf && (pend_ff != 64'd0 || att_ff != 32'd0 || !bind_ok)) bad = 1'b1;
         if (is_trial && (floor_ff == '1 || pend_ff != floor_plus ||
                          att_ff > {24'd0, max_trial_ff} || !bind_ok)) bad = 1'b1;
      end

      obj_push  = byte_valid && last_byte;
      obj_entry = '0;
      obj_entry.bad = bad;
      obj_entry.digest = digest_ff;
      if (!bad) begin
         obj_entry.generation = gen_ff;
         if (format_ff) begin
            obj_entry.slot = kind_ff[3:0];
         end else begin
            obj_entry.kind          = kind_ff[3:0];
            obj_entry.floor_seq     = floor_ff;
            obj_entry.trial_seq     = pend_ff;
            obj_entry.attempts_left = att_ff[7:0];
            obj_entry.boot_seq      = aseq_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 8'd0;
         crc_ff   <= 32'hFFFF_FFFF;
         err_ff   <= 1'b0;
         shift_ff <= 64'd0;
         dz_ff    <= 2'b11;
      end else if (byte_valid) begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         err_ff   <= err_in;
         shift_ff <= shift_in;
         dz_ff    <= dz_in;
      end
   end

   // captured fields, no reset
   always_ff @(posedge clock) begin
      if (byte_valid) begin
         if (p == 8'd27 && format_ff) kind_ff <= hi;
         if (p == 8'd31 && !format_ff) kind_ff <= hi;
         if (p == 8'd39) gen_ff <= shift_in;
         if (in_digest && off[2:0] == 3'd7) digest_ff[off[5:3]] <= shift_in;
         if (!in_digest && !format_ff) begin
            if (p == 8'd47)  floor_ff <= shift_in;
            if (p == 8'd55)  pend_ff  <= shift_in;
            if (p == 8'd59)  att_ff   <= hi;
            if (p == 8'd135) aseq_ff  <= shift_in;
         end
      end
   end
endmodule
`default_nettype wire

// ===== design/jrv_queue.sv =====
// Two-entry queue of finished object summaries between parser and emitter.
// Uses jrv_pkg for the entry type.
`default_nettype none
module jrv_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  jrv_pkg::obj_type     push_entry,
   input  wire logic            pop,
   output logic                 full,
   output logic                 empty,
   output jrv_pkg::obj_type     head
);
   import jrv_pkg::*;

   obj_type     store_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  count_ff;
   logic        do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = store_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop)  rd_ff <= !rd_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ff] <= push_entry;
   end
endmodule
`default_nettype wire

// ===== design/jrv_back.sv =====
// Result emitter: turns one queued object into a status word and, if valid, eight digest words.
// Uses jrv_pkg for the entry type.
`default_nettype none
module jrv_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_empty,
   input  jrv_pkg::obj_type     q_head,
   output logic                 q_pop,
   input  wire logic            rsp_pop,
   output logic                 rsp_empty,
   output logic                 rsp_status,
   output logic [3:0]           rsp_kind,
   output logic [3:0]           rsp_slot,
   output logic [63:0]          rsp_generation,
   output logic [63:0]          rsp_floor_seq,
   output logic [63:0]          rsp_trial_seq,
   output logic [7:0]           rsp_attempts_left,
   output logic [63:0]          rsp_boot_seq,
   output logic [63:0]          rsp_digest_word,
   output logic [3:0]           rsp_word_index,
   output logic [0:0]           rsp_last_flag
);
   import jrv_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic       take;
   logic       final_word;
   logic [2:0] dsel;

   always_comb begin
      rsp_empty  = q_empty;
      take       = rsp_pop && !q_empty;
      final_word = q_head.bad || idx_ff == 4'd8;
      q_pop      = take && final_word;
      idx_in     = idx_ff;
      if (take) idx_in = final_word ? 4'd0 : idx_ff + 4'd1;
      dsel       = 3'(idx_ff - 4'd1);

      rsp_status        = 1'b0;
      rsp_kind          = '0;
      rsp_slot          = '0;
      rsp_generation    = '0;
      rsp_floor_seq     = '0;
      rsp_trial_seq     = '0;
      rsp_attempts_left = '0;
      rsp_boot_seq      = '0;
      rsp_digest_word   = '0;
      rsp_word_index    = idx_ff;
      rsp_last_flag     = final_word;
      if (idx_ff == 4'd0) begin
         rsp_status        = q_head.bad;
         rsp_kind          = q_head.kind;
         rsp_slot          = q_head.slot;
         rsp_generation    = q_head.generation;
         rsp_floor_seq     = q_head.floor_seq;
         rsp_trial_seq     = q_head.trial_seq;
         rsp_attempts_left = q_head.attempts_left;
         rsp_boot_seq      = q_head.boot_seq;
      end else begin
         rsp_digest_word = q_head.digest[dsel];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 4'd0;
      else       idx_ff <= idx_in;
   end
endmodule
`default_nettype wire
